@@ rtl/core/tbc_pkg.sv @@
// Package for the triangle barycentric weight block.
// Holds widths, pipeline depths, the structs passed between the stages and the clip helper.
package tbc_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int NUM_COORDS       = 12;
    localparam int PROD_BITS        = 72;
    localparam int DIV_STEPS        = PROD_BITS + WEIGHT_FRAC_BITS;
    localparam int QUOT_BITS        = DIV_STEPS + 3;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [PROD_BITS-1:0] den;
        logic signed [PROD_BITS-1:0] nv;
        logic signed [PROD_BITS-1:0] nw;
        logic                        degen;
    } t_fq;

    typedef struct packed {
        logic                        vld;
        logic [PROD_BITS-1:0]        den;
        logic [PROD_BITS-1:0]        v_rem;
        logic [DIV_STEPS-1:0]        v_num;
        logic [PROD_BITS-1:0]        w_rem;
        logic [DIV_STEPS-1:0]        w_num;
        logic                        v_neg;
        logic                        w_neg;
        logic                        degen;
    } t_div;

    typedef struct packed {
        logic [15:0] val;
        logic        clip;
    } t_sat;

    function automatic t_sat sat16(input logic signed [QUOT_BITS-1:0] x);
        t_sat s;
        if (x > QUOT_BITS'(32767)) begin
            s.val  = 16'h7fff;
            s.clip = 1'b1;
        end else if (x < -QUOT_BITS'(32768)) begin
            s.val  = 16'h8000;
            s.clip = 1'b1;
        end else begin
            s.val  = x[15:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage

@@ rtl/core/triangle_barycentric_coords.sv @@
// Top level of the triangle barycentric weight block.
// Depends on tbc_pkg, tbc_front, tbc_fifo and tbc_back.
//
// Takes one point and triangle (signed Q8.8) per cycle when not stalled and returns the
// weights u, v, w in signed Q4.12, truncated toward zero and clipped, with degenerate and
// saturated flags. Throughput is one item per clock while neither side stalls. The path
// runs through the front registers for edge vectors, products, dot products, the
// two-stage 36 x 36 multipliers and the numerators, then the four-entry queue, the divider
// pipeline (an entry stage, then one quotient bit per stage) and the output register.
// Either side may stall; the queue lets the front keep running while the back waits.
module triangle_barycentric_coords (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z, 16 bits each
    input  logic [191:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // weight_u, weight_v, weight_w, 16 bits each
    output logic [47:0]    m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]     m_axis_tuser
);
    import tbc_pkg::*;

    logic front_en;
    logic front_vld;
    t_fq  front_item;
    t_fq  q_item;
    logic q_full;
    logic q_empty;
    logic back_adv;
    logic q_pop;

    assign front_en      = !front_vld || !q_full;
    assign s_axis_tready = front_en;
    assign q_pop         = back_adv && !q_empty;

    tbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_vld   (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_vld   (front_vld),
        .o_item  (front_item)
    );

    tbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_en && front_vld),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tbc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (!q_empty),
        .i_item  (q_item),
        .o_adv   (back_adv),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

@@ rtl/core/tbc_mul.sv @@
// Two-stage signed 36 x 36 multiplier built from four partial products.
// Depends on tbc_pkg for the product width.
module tbc_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [35:0]                    i_a,
    input  logic signed [35:0]                    i_b,
    output logic signed [tbc_pkg::PROD_BITS-1:0]  o_p
);
    import tbc_pkg::*;

    logic signed [35:0] r_hh;
    logic signed [36:0] r_hl;
    logic signed [36:0] r_lh;
    logic        [35:0] r_ll;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= $signed(i_a[35:18]) * $signed(i_b[35:18]);
            r_hl <= $signed(i_a[35:18]) * $signed({1'b0, i_b[17:0]});
            r_lh <= $signed({1'b0, i_a[17:0]}) * $signed(i_b[35:18]);
            r_ll <= i_a[17:0] * i_b[17:0];
            o_p  <= (PROD_BITS'(r_hh) <<< 36)
                  + ((PROD_BITS'(r_hl) + PROD_BITS'(r_lh)) <<< 18)
                  + $signed({36'd0, r_ll});
        end
    end

endmodule

@@ rtl/core/tbc_front.sv @@
// Front pipeline: edge vectors, dot products, Gram determinant and the two numerators.
// Depends on tbc_pkg and tbc_mul.
module tbc_front (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_vld,
    input  logic [tbc_pkg::NUM_COORDS*16-1:0]         i_data,
    output logic                                      o_vld,
    output tbc_pkg::t_fq                              o_item
);
    import tbc_pkg::*;

    logic signed [COORD_BITS-1:0] crd [NUM_COORDS];
    logic signed [16:0]           r_e  [9];
    logic signed [33:0]           r_pr [15];
    logic signed [35:0]           r_d  [5];
    logic signed [PROD_BITS-1:0]  mp   [6];
    logic [5:0]                   r_vld;
    t_fq                          r_out;

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            crd[k] = i_data[16*k +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k]     <= 17'(crd[6+k]) - 17'(crd[3+k]);
                r_e[3+k]   <= 17'(crd[9+k]) - 17'(crd[3+k]);
                r_e[6+k]   <= 17'(crd[k])   - 17'(crd[3+k]);
                r_pr[k]    <= r_e[k]   * r_e[k];
                r_pr[3+k]  <= r_e[k]   * r_e[3+k];
                r_pr[6+k]  <= r_e[3+k] * r_e[3+k];
                r_pr[9+k]  <= r_e[6+k] * r_e[k];
                r_pr[12+k] <= r_e[6+k] * r_e[3+k];
            end
            for (int j = 0; j < 5; j++) begin
                r_d[j] <= 36'(r_pr[3*j]) + 36'(r_pr[3*j+1]) + 36'(r_pr[3*j+2]);
            end
            r_out.den   <= mp[0] - mp[1];
            r_out.nv    <= mp[2] - mp[3];
            r_out.nw    <= mp[4] - mp[5];
            r_out.degen <= (mp[0] == mp[1]);
        end
    end

    tbc_mul u_m0 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[0]), .i_b(r_d[2]), .o_p(mp[0]));
    tbc_mul u_m1 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[1]), .i_b(r_d[1]), .o_p(mp[1]));
    tbc_mul u_m2 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[2]), .i_b(r_d[3]), .o_p(mp[2]));
    tbc_mul u_m3 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[1]), .i_b(r_d[4]), .o_p(mp[3]));
    tbc_mul u_m4 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[0]), .i_b(r_d[4]), .o_p(mp[4]));
    tbc_mul u_m5 (.i_clk(i_clk), .i_en(i_en), .i_a(r_d[1]), .i_b(r_d[3]), .o_p(mp[5]));

    assign o_vld  = r_vld[5];
    assign o_item = r_out;

endmodule

@@ rtl/core/tbc_fifo.sv @@
// Short queue between the front and back pipelines.
// Depends on tbc_pkg for the item struct and depth.
module tbc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbc_pkg::t_fq  i_data,
    input  logic          i_pop,
    output tbc_pkg::t_fq  o_data,
    output logic          o_full,
    output logic          o_empty
);
    import tbc_pkg::*;

    t_fq                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

@@ rtl/core/tbc_back.sv @@
// Back pipeline: one restoring divide step per stage for v and w, then u, clipping and output register.
// Depends on tbc_pkg.
module tbc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  tbc_pkg::t_fq  i_item,
    output logic          o_adv,
    output logic          o_vld,
    input  logic          i_rdy,
    output logic [47:0]   o_data,
    output logic [1:0]    o_user
);
    import tbc_pkg::*;

    t_div r_st [DIV_STEPS+1];
    t_div n_st [DIV_STEPS+1];
    logic        r_ovld;
    logic [47:0] r_odata;
    logic [1:0]  r_ouser;
    logic        out_free;

    logic [PROD_BITS-1:0]          mag_v;
    logic [PROD_BITS-1:0]          mag_w;
    logic [PROD_BITS:0]            tv;
    logic [PROD_BITS:0]            tw;
    logic signed [QUOT_BITS-1:0]   qv;
    logic signed [QUOT_BITS-1:0]   qw;
    logic signed [QUOT_BITS-1:0]   qu;
    t_sat                          su;
    t_sat                          sv;
    t_sat                          sw;

    assign out_free = !r_ovld || i_rdy;
    assign o_adv    = !r_st[DIV_STEPS].vld || out_free;

    always_comb begin
        mag_v = i_item.nv[PROD_BITS-1] ? PROD_BITS'(-i_item.nv) : i_item.nv;
        mag_w = i_item.nw[PROD_BITS-1] ? PROD_BITS'(-i_item.nw) : i_item.nw;
        n_st[0].vld   = i_vld;
        n_st[0].den   = i_item.den;
        n_st[0].v_rem = '0;
        n_st[0].w_rem = '0;
        n_st[0].v_num = {mag_v, WEIGHT_FRAC_BITS'(0)};
        n_st[0].w_num = {mag_w, WEIGHT_FRAC_BITS'(0)};
        n_st[0].v_neg = i_item.nv[PROD_BITS-1];
        n_st[0].w_neg = i_item.nw[PROD_BITS-1];
        n_st[0].degen = i_item.degen;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_st[k+1] = r_st[k];
            tv = {r_st[k].v_rem, r_st[k].v_num[DIV_STEPS-1]};
            tw = {r_st[k].w_rem, r_st[k].w_num[DIV_STEPS-1]};
            if (tv >= {1'b0, r_st[k].den}) begin
                n_st[k+1].v_rem = PROD_BITS'(tv - {1'b0, r_st[k].den});
                n_st[k+1].v_num = {r_st[k].v_num[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_st[k+1].v_rem = tv[PROD_BITS-1:0];
                n_st[k+1].v_num = {r_st[k].v_num[DIV_STEPS-2:0], 1'b0};
            end
            if (tw >= {1'b0, r_st[k].den}) begin
                n_st[k+1].w_rem = PROD_BITS'(tw - {1'b0, r_st[k].den});
                n_st[k+1].w_num = {r_st[k].w_num[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_st[k+1].w_rem = tw[PROD_BITS-1:0];
                n_st[k+1].w_num = {r_st[k].w_num[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_st[k].vld <= 1'b0;
            end
        end else if (o_adv) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        qv = $signed({3'b000, r_st[DIV_STEPS].v_num});
        qw = $signed({3'b000, r_st[DIV_STEPS].w_num});
        if (r_st[DIV_STEPS].v_neg) qv = -qv;
        if (r_st[DIV_STEPS].w_neg) qw = -qw;
        qu = $signed(QUOT_BITS'(1) << WEIGHT_FRAC_BITS) - qv - qw;
        su = sat16(qu);
        sv = sat16(qv);
        sw = sat16(qw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_free) begin
            r_ovld <= r_st[DIV_STEPS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_st[DIV_STEPS].degen) begin
                r_odata <= '0;
                r_ouser <= 2'b01;
            end else begin
                r_odata <= {sw.val, sv.val, su.val};
                r_ouser <= {su.clip | sv.clip | sw.clip, 1'b0};
            end
        end
    end

    assign o_vld  = r_ovld;
    assign o_data = r_odata;
    assign o_user = r_ouser;

endmodule

@@ tb/tb.sv @@
// Testbench for triangle_barycentric_coords: streams point/triangle sets through the block
// with random valid and ready gaps and checks each weight result against a behavioural model.
// Depends on tbc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
    import tbc_pkg::*;

    typedef struct packed {
        logic signed [15:0] vcz, vcy, vcx, vbz, vby, vbx, vaz, vay, vax, pz, py, px;
    } t_tri;

    typedef struct packed {
        logic [15:0] wu, wv, ww;
        logic        degen, sat;
    } t_wts;

    localparam int WDOG_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    t_tri   tri_queue[$];
    t_wts   weights_due[$];
    int     idle_in_pct = 0, idle_out_pct = 0;
    int     n_sent = 0, n_checked = 0, n_errors = 0, n_degen = 0, n_sat = 0;
    int     quiet_cycles = 0;
    bit     feed_done = 1'b0;

    triangle_barycentric_coords dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] clip16(input logic signed [127:0] x, inout bit sat);
        if (x > 128'sd32767) begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (x < -128'sd32768) begin
            sat = 1'b1;
            return 16'h8000;
        end
        return x[15:0];
    endfunction

    function automatic t_wts barycentric(input t_tri t);
        logic signed [127:0] e0 [3], e1 [3], e2 [3];
        logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
        t_wts r;
        bit sat;
        e0[0] = t.vbx - t.vax; e0[1] = t.vby - t.vay; e0[2] = t.vbz - t.vaz;
        e1[0] = t.vcx - t.vax; e1[1] = t.vcy - t.vay; e1[2] = t.vcz - t.vaz;
        e2[0] = t.px - t.vax;  e2[1] = t.py - t.vay;  e2[2] = t.pz - t.vaz;
        d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
        d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
        d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
        d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
        d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
        den = d00*d11 - d01*d01;
        r = '0;
        sat = 1'b0;
        if (den == 0) begin
            r.degen = 1'b1;
            return r;
        end
        nv = d11*d20 - d01*d21;
        nw = d00*d21 - d01*d20;
        qv = (nv <<< WEIGHT_FRAC_BITS) / den;
        qw = (nw <<< WEIGHT_FRAC_BITS) / den;
        qu = (128'sd1 <<< WEIGHT_FRAC_BITS) - qv - qw;
        r.wu = clip16(qu, sat);
        r.wv = clip16(qv, sat);
        r.ww = clip16(qw, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                           : 16'h8000 + 16'($urandom_range(0, 3));
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    task automatic add_tri(input t_tri t);
        tri_queue.push_back(t);
    endtask

    initial begin
        t_tri t;
        t = '0;
        add_tri(t);
        t.vbx = 16'sh0100; t.vcy = 16'sh0100; t.px = 16'sh0040; t.py = 16'sh0040;
        add_tri(t);
        t.px = 16'sh7fff; t.py = 16'sh7fff; t.pz = 16'sh7fff;
        add_tri(t);
        t.px = 16'sh8000; t.py = 16'sh8000; t.pz = 16'sh8000;
        add_tri(t);
        t.vcx = 16'sh0200; t.vcy = 16'sh0000;
        add_tri(t);
        t = '0;
        t.vbx = 16'sh0001; t.vcy = 16'sh0001; t.px = 16'sh7fff; t.pz = 16'sh8000;
        add_tri(t);
        {t.vax, t.vay, t.vaz} = {16'sh8000, 16'sh8000, 16'sh8000};
        {t.vbx, t.vby, t.vbz} = {16'sh7fff, 16'sh8000, 16'sh8000};
        {t.vcx, t.vcy, t.vcz} = {16'sh8000, 16'sh7fff, 16'sh7fff};
        {t.px, t.py, t.pz} = {16'sh7fff, 16'sh7fff, 16'sh7fff};
        add_tri(t);
        t = {12{16'hffff}};
        add_tri(t);
        t = {12{16'h5555}};
        add_tri(t);
        t = {12{16'haaaa}};
        add_tri(t);
        for (int i = 0; i < 860; i++) begin
            t = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord()};
            if ($urandom_range(0, 15) == 0) begin
                {t.vcx, t.vcy, t.vcz} = {t.vbx, t.vby, t.vbz};
            end
            add_tri(t);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_in_pct = 25; idle_out_pct = 60;
        wait (n_sent >= 300);
        idle_in_pct = 60; idle_out_pct = 25;
        wait (n_sent >= 600);
        idle_in_pct = 0; idle_out_pct = 0;
        wait (tri_queue.size() == 0 && !s_axis_tvalid);
        feed_done = 1'b1;
        wait (weights_due.size() == 0);
        repeat (120) @(posedge i_clk);
        $display("Checked %0d results from %0d transfers in three idling phases",
                 n_checked, n_sent);
        $display("  degenerate cases: %0d, saturated cases: %0d", n_degen, n_sat);
        if (n_errors == 0 && weights_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                weights_due.push_back(barycentric(t_tri'(s_axis_tdata)));
                n_sent <= n_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tri_queue.size() > 0 && $urandom_range(0, 99) >= idle_in_pct) begin
                    s_axis_tdata  <= tri_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= idle_out_pct);
        end
    end

    always @(posedge i_clk) begin
        t_wts got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tuser[0], m_axis_tuser[1]};
            if (weights_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors++;
            end else begin
                want = weights_due.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch u/v/w/degen/sat expected %h %h %h %b %b, got %h %h %h %b %b",
                             $time, want.wu, want.wv, want.ww, want.degen, want.sat,
                             got.wu, got.wv, got.ww, got.degen, got.sat);
                    n_errors++;
                end
                n_degen += want.degen;
                n_sat   += want.sat;
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

endmodule
